// ===== rtl/lru_pr_pkg.sv =====
// LRU page replacement: shared types and constants.
// Word formats, controller states and fixed field widths; no dependencies.
`timescale 1ns / 1ps

package lru_pr_pkg;

  localparam int PAGE_W       = 16;
  localparam int FRAME_IDX_W  = 3;
  localparam int COUNT_W      = 16;
  localparam int CFG_W        = 4;
  localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
  localparam logic [COUNT_W-1:0] FAULT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              last_of_string;
  } in_word_t;

  typedef struct packed {
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic                   evicted_valid;
    logic [PAGE_W-1:0]      evicted_page;
    logic [COUNT_W-1:0]     fault_count;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

// ===== rtl/lru_page_replacement_top.sv =====
// LRU page replacement table, top level.
// Uses lru_pr_pkg and one lru_pr_ram holding the resident page of each frame.
//
//   channel  | ports                    | handshake
//   ---------+--------------------------+--------------------------------------
//   input    | start, busy, in_word     | word taken when start && !busy
//   result   | out_valid, out_word      | one-cycle strobe, cannot be stalled
//   config   | cfg_we, cfg_wdata        | frames_in_use written when cfg_we
//
// An accepted word reads the page RAM once per active frame, then passes through
// the update state, which registers its result.
// Reset: frames_in_use = 8, all frames empty, fault count zero; no clear pass.
// The result register frees the core, so the next word is taken in the
// cycle the previous result is shown.
`timescale 1ns / 1ps

module lru_page_replacement_top #(
  parameter int FRAME_COUNT = 8,
  parameter int PAGE_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  lru_pr_pkg::in_word_t          in_word,
  output logic                          out_valid,
  output lru_pr_pkg::out_word_t         out_word,
  input  logic                          cfg_we,
  input  logic [lru_pr_pkg::CFG_W-1:0]  cfg_wdata
);

  import lru_pr_pkg::*;

  localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int RW = FW;
  localparam int CW = $clog2(FRAME_COUNT + 1);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]     frames_in_use_r;
  logic [CW-1:0]        n_act;
  logic [CW-1:0]        cnt_r;
  logic                 issue;
  logic                 chk_vld_r;
  logic [FW-1:0]        chk_idx_r;

  logic [PAGE_BITS-1:0] page_r;
  logic                 last_r;
  logic [PAGE_BITS-1:0] rd_page;

  logic                 hit_r, empty_r;
  logic [FW-1:0]        hit_idx_r, empty_idx_r, lru_idx_r;
  logic [RW-1:0]        lru_rank_r;
  logic [PAGE_BITS-1:0] lru_page_r;

  logic [FRAME_COUNT-1:0] valid_r, valid_nxt;
  logic [RW-1:0]          rank_r [FRAME_COUNT];
  logic [RW-1:0]          rank_nxt [FRAME_COUNT];
  logic [COUNT_W-1:0]     count_r, count_nxt;

  logic [FW-1:0]        sel;
  logic [RW:0]          older;
  logic                 accept;
  logic                 upd;
  logic                 ram_we;
  logic                 chk_valid, chk_match;
  logic [31:0]          sel_ext, ev_ext, pg_ext;

  out_word_t            out_word_r, out_word_nxt;
  logic                 out_valid_r;

  // active frame count: 0 acts as 1, above FRAME_COUNT clamps
  always_comb begin
    if (frames_in_use_r == '0) begin
      n_act = CW'(1);
    end else if (32'(frames_in_use_r) > FRAME_COUNT) begin
      n_act = CW'(FRAME_COUNT);
    end else begin
      n_act = CW'(frames_in_use_r);
    end
  end

  assign accept = start && (state_r == ST_IDLE);
  assign issue  = (state_r == ST_SCAN) && (cnt_r < n_act);
  assign upd    = (state_r == ST_UPDATE);
  assign pg_ext = 32'(in_word.page);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_SCAN;
      ST_SCAN:   if (!issue && !chk_vld_r) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    unique case (state_r)
      ST_IDLE: busy = 1'b0;
      default: busy = 1'b1;
    endcase
  end

  lru_pr_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (FRAME_COUNT)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sel),
    .wdata (page_r),
    .raddr (cnt_r[FW-1:0]),
    .rdata (rd_page)
  );

  assign chk_valid = valid_r[chk_idx_r];
  assign chk_match = chk_valid && (rd_page == page_r);

  // frame choice and recency update
  always_comb begin
    if (hit_r) begin
      sel   = hit_idx_r;
      older = {1'b0, rank_r[hit_idx_r]};
    end else if (empty_r) begin
      sel   = empty_idx_r;
      older = (RW+1)'(FRAME_COUNT);
    end else begin
      sel   = lru_idx_r;
      older = {1'b0, lru_rank_r};
    end
  end

  assign ram_we = upd && !hit_r;

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    count_nxt = count_r;
    if (upd) begin
      for (int j = 0; j < FRAME_COUNT; j++) begin
        if ((FW'(j) != sel) && valid_r[j] && ({1'b0, rank_r[j]} < older)) begin
          rank_nxt[j] = rank_r[j] + RW'(1);
        end
      end
      rank_nxt[sel]  = '0;
      valid_nxt[sel] = 1'b1;
      if (!hit_r && (count_r != FAULT_MAX)) begin
        count_nxt = count_r + COUNT_W'(1);
      end
    end
  end

  assign sel_ext = 32'(sel);
  assign ev_ext  = 32'(lru_page_r);

  always_comb begin
    out_word_nxt.hit           = hit_r;
    out_word_nxt.frame_index   = sel_ext[FRAME_IDX_W-1:0];
    out_word_nxt.evicted_valid = !hit_r && !empty_r;
    out_word_nxt.evicted_page  = (!hit_r && !empty_r) ? ev_ext[PAGE_W-1:0] : '0;
    out_word_nxt.fault_count   = count_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      frames_in_use_r <= CFG_RESET;
      valid_r         <= '0;
      count_r         <= '0;
      out_valid_r     <= 1'b0;
      chk_vld_r       <= 1'b0;
      cnt_r           <= '0;
      for (int j = 0; j < FRAME_COUNT; j++) rank_r[j] <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= upd;
      chk_vld_r   <= issue;
      if (cfg_we) frames_in_use_r <= cfg_wdata;
      if (accept) begin
        cnt_r <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (upd && last_r) begin
        valid_r <= '0;
        count_r <= '0;
        for (int j = 0; j < FRAME_COUNT; j++) rank_r[j] <= '0;
      end else begin
        valid_r <= valid_nxt;
        count_r <= count_nxt;
        rank_r  <= rank_nxt;
      end
    end
  end

  // scan results and payload
  always_ff @(posedge clk) begin
    chk_idx_r <= cnt_r[FW-1:0];
    if (upd) out_word_r <= out_word_nxt;
    if (accept) begin
      page_r  <= pg_ext[PAGE_BITS-1:0];
      last_r  <= in_word.last_of_string;
      hit_r   <= 1'b0;
      empty_r <= 1'b0;
    end else if (chk_vld_r) begin
      if (chk_match && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= chk_idx_r;
      end
      if (!chk_valid && !empty_r) begin
        empty_r     <= 1'b1;
        empty_idx_r <= chk_idx_r;
      end
      if ((chk_idx_r == '0) || (rank_r[chk_idx_r] > lru_rank_r)) begin
        lru_idx_r  <= chk_idx_r;
        lru_rank_r <= rank_r[chk_idx_r];
        lru_page_r <= rd_page;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_out_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_UPDATE))
    else $error("result strobe without update cycle");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.hit) |-> !out_word.evicted_valid)
    else $error("hit reported an eviction");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && last_r) |=> (valid_r == '0) && (count_r == '0))
    else $error("table not cleared after last word");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_SCAN) && (cnt_r == '0))
    else $error("accepted word did not start a scan");

endmodule

// ===== rtl/lru_pr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module lru_pr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/sv/lru_page_replacement_top_test.sv =====
// Self-checking testbench for lru_page_replacement_top: directed table, then
// random reference strings under several frame counts.
// Depends on lru_pr_pkg and the RTL only.
`timescale 1ns / 1ps

module lru_page_replacement_top_test;
  import lru_pr_pkg::*;

  localparam int FRAMES = 8;

  typedef enum bit {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    in_word_t          w;
    logic [CFG_W-1:0]  cfg;
    bit                typed;
    out_word_t         want;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  in_word_t         in_word = '0;
  logic             out_valid;
  out_word_t        out_word;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // typed expectation rides along with the word it belongs to
  bit               typed_on = 1'b0;
  out_word_t        typed_want = '0;

  out_word_t        pending_lookups[$];
  int               mismatches = 0;
  int               n_words = 0;
  int               n_hits = 0;
  int               n_evict = 0;
  int               n_sat = 0;

  // table model
  logic [PAGE_W-1:0]  fr_page[FRAMES];
  bit                 fr_valid[FRAMES];
  int                 fr_rank[FRAMES];
  logic [COUNT_W-1:0] faults;
  logic [CFG_W-1:0]   frames_cfg;

  localparam logic [CFG_W-1:0] PHASE_FRAMES[10] =
    '{4'd3, 4'd0, 4'd15, 4'd8, 4'd1, 4'd5, 4'd2, 4'd7, 4'd4, 4'd6};

  dir_row_t dir_tab[0:29] = '{
    '{ROW_WORD, '{16'h0000, 1'b0}, 4'd0, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 16'd1}},
    '{ROW_WORD, '{16'hFFFF, 1'b0}, 4'd0, 1'b1, '{1'b0, 3'd1, 1'b0, 16'h0000, 16'd2}},
    '{ROW_WORD, '{16'h0000, 1'b0}, 4'd0, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 16'd2}},
    '{ROW_WORD, '{16'hFFFF, 1'b1}, 4'd0, 1'b1, '{1'b1, 3'd1, 1'b0, 16'h0000, 16'd2}},
    '{ROW_WORD, '{16'h1234, 1'b0}, 4'd0, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 16'd1}},
    '{ROW_CFG,  '{16'h0000, 1'b0}, 4'd1, 1'b0, '0},
    '{ROW_WORD, '{16'hAAAA, 1'b0}, 4'd0, 1'b1, '{1'b0, 3'd0, 1'b1, 16'h1234, 16'd2}},
    '{ROW_WORD, '{16'h5555, 1'b0}, 4'd0, 1'b1, '{1'b0, 3'd0, 1'b1, 16'hAAAA, 16'd3}},
    '{ROW_CFG,  '{16'h0000, 1'b0}, 4'd0, 1'b0, '0},
    '{ROW_WORD, '{16'h5555, 1'b0}, 4'd0, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 16'd3}},
    '{ROW_WORD, '{16'h0001, 1'b0}, 4'd0, 1'b1, '{1'b0, 3'd0, 1'b1, 16'h5555, 16'd4}},
    '{ROW_CFG,  '{16'h0000, 1'b0}, 4'd15, 1'b0, '0},
    '{ROW_WORD, '{16'h0002, 1'b0}, 4'd0, 1'b1, '{1'b0, 3'd1, 1'b0, 16'h0000, 16'd5}},
    '{ROW_CFG,  '{16'h0000, 1'b0}, 4'd1, 1'b0, '0},
    '{ROW_WORD, '{16'h0002, 1'b0}, 4'd0, 1'b1, '{1'b0, 3'd0, 1'b1, 16'h0001, 16'd6}},
    '{ROW_CFG,  '{16'h0000, 1'b0}, 4'd2, 1'b0, '0},
    // page 0002 now sits in frames 0 and 1; frame 0 wins
    '{ROW_WORD, '{16'h0002, 1'b0}, 4'd0, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 16'd6}},
    '{ROW_WORD, '{16'h0003, 1'b0}, 4'd0, 1'b1, '{1'b0, 3'd1, 1'b1, 16'h0002, 16'd7}},
    '{ROW_CFG,  '{16'h0000, 1'b0}, 4'd8, 1'b0, '0},
    '{ROW_WORD, '{16'h0004, 1'b1}, 4'd0, 1'b1, '{1'b0, 3'd2, 1'b0, 16'h0000, 16'd8}},
    '{ROW_WORD, '{16'h8000, 1'b0}, 4'd0, 1'b0, '0},
    '{ROW_WORD, '{16'h4001, 1'b0}, 4'd0, 1'b0, '0},
    '{ROW_WORD, '{16'h2002, 1'b0}, 4'd0, 1'b0, '0},
    '{ROW_WORD, '{16'h1003, 1'b0}, 4'd0, 1'b0, '0},
    '{ROW_WORD, '{16'h0804, 1'b0}, 4'd0, 1'b0, '0},
    '{ROW_WORD, '{16'h0405, 1'b0}, 4'd0, 1'b0, '0},
    '{ROW_WORD, '{16'h0206, 1'b0}, 4'd0, 1'b0, '0},
    '{ROW_WORD, '{16'h0107, 1'b0}, 4'd0, 1'b0, '0},
    '{ROW_WORD, '{16'h8000, 1'b0}, 4'd0, 1'b0, '0},
    '{ROW_WORD, '{16'h7FFF, 1'b1}, 4'd0, 1'b0, '0}
  };

  lru_page_replacement_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d words outstanding", pending_lookups.size());
    $display("end of test: mismatches");
    $finish;
  end

  function automatic void clear_table();
    for (int j = 0; j < FRAMES; j++) begin
      fr_page[j] = '0;
      fr_valid[j] = 1'b0;
      fr_rank[j] = 0;
    end
    faults = '0;
  endfunction

  function automatic out_word_t lru_reference(in_word_t w);
    out_word_t r;
    int n;
    int f;
    int old;
    bit found;
    bit empty;
    r = '0;
    f = 0;
    found = 1'b0;
    empty = 1'b0;
    n = (frames_cfg == 0) ? 1 : (frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg);
    for (int j = 0; j < n; j++)
      if (!found && fr_valid[j] && fr_page[j] == w.page) begin
        found = 1'b1;
        f = j;
      end
    if (found) begin
      old = fr_rank[f];
    end else begin
      for (int j = 0; j < n; j++)
        if (!empty && !fr_valid[j]) begin
          empty = 1'b1;
          f = j;
        end
      if (empty) begin
        fr_valid[f] = 1'b1;
        old = FRAMES;
      end else begin
        f = 0;
        for (int j = 1; j < n; j++)
          if (fr_rank[j] > fr_rank[f]) f = j;
        r.evicted_valid = 1'b1;
        r.evicted_page = fr_page[f];
        old = fr_rank[f];
      end
      fr_page[f] = w.page;
      if (faults != FAULT_MAX) faults = faults + 1'b1;
    end
    for (int j = 0; j < FRAMES; j++)
      if (j != f && fr_valid[j] && fr_rank[j] < old) fr_rank[j]++;
    fr_rank[f] = 0;
    r.hit = found;
    r.frame_index = 3'(f);
    r.fault_count = faults;
    if (w.last_of_string) clear_table();
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40)
      $display("%0t: %s got %0h want %0h", $realtime, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      clear_table();
      frames_cfg = CFG_RESET;
      pending_lookups.delete();
    end else begin
      if (out_valid) begin
        if (pending_lookups.size() == 0) begin
          report_mismatch("unexpected word", 32'(out_word), 32'h0);
        end else begin
          want = pending_lookups.pop_front();
          if (out_word.hit !== want.hit)
            report_mismatch("hit", 32'(out_word.hit), 32'(want.hit));
          if (out_word.frame_index !== want.frame_index)
            report_mismatch("frame_index", 32'(out_word.frame_index), 32'(want.frame_index));
          if (out_word.evicted_valid !== want.evicted_valid)
            report_mismatch("evicted_valid", 32'(out_word.evicted_valid),
                            32'(want.evicted_valid));
          if (out_word.evicted_page !== want.evicted_page)
            report_mismatch("evicted_page", 32'(out_word.evicted_page),
                            32'(want.evicted_page));
          if (out_word.fault_count !== want.fault_count)
            report_mismatch("fault_count", 32'(out_word.fault_count), 32'(want.fault_count));
        end
        n_words++;
        if (out_word.hit) n_hits++;
        if (out_word.evicted_valid) n_evict++;
        if (out_word.fault_count == FAULT_MAX) n_sat++;
      end
      if (start && !busy) begin
        want = lru_reference(in_word);
        pending_lookups.push_back(typed_on ? typed_want : want);
      end
      if (cfg_we) frames_cfg = cfg_wdata;
    end
  end

  // returns at the edge that takes the word; start stays high
  task automatic drive_word(input in_word_t w, input bit may_idle, input bit typed,
                            input out_word_t want);
    if (may_idle && $urandom_range(99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    typed_on <= typed;
    typed_want <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending_lookups.size() != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    in_word_t w;
    logic [PAGE_W-1:0] pool[16];
    int pool_n;
    int str_left;
    str_left = 0;
    pool_n = 1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) write_frames(dir_tab[i].cfg);
      else drive_word(dir_tab[i].w, 1'b1, dir_tab[i].typed, dir_tab[i].want);
    end

    for (int p = 0; p < 10; p++) begin
      write_frames(PHASE_FRAMES[p]);
      for (int k = 0; k < 120; k++) begin
        if (str_left == 0) begin
          str_left = $urandom_range(40, 4);
          pool_n = $urandom_range(16, 2);
          for (int j = 0; j < 16; j++) pool[j] = 16'($urandom);
        end
        if ($urandom_range(99) == 0) drain();
        w.page = ($urandom_range(9) == 0) ? 16'($urandom) : pool[$urandom_range(pool_n - 1)];
        str_left--;
        w.last_of_string = (str_left == 0) || ($urandom_range(49) == 0);
        if (w.last_of_string) str_left = 0;
        drive_word(w, p != 3, 1'b0, '0);
      end
    end

    drain();
    if (pending_lookups.size() != 0)
      report_mismatch("words never returned", 32'(pending_lookups.size()), 32'h0);
    $display("%0d words checked: %0d hits, %0d evictions, %0d at saturated count",
             n_words, n_hits, n_evict, n_sat);
    $display("frame counts between 0 and 15 incl. out-of-range, mid-string count changes, "
             , "random gaps");
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== lru_page_replacement_top.f =====
rtl/lru_pr_pkg.sv
rtl/lru_pr_ram.sv
rtl/lru_page_replacement_top.sv
tb/sv/lru_page_replacement_top_test.sv
